/* rtl/bpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants of the buffer pool free/ready queues
// Action and status codes, widths and the request record passed front to back.
// ----------------------------------------------------------------------------
package bpq_pkg;
	localparam int MAX_BUFFERS  = 128;
	localparam int BUFFER_BYTES = 1024;
	localparam int ID_W   = 7;
	localparam int LVL_W  = 8;
	localparam int LEN_W  = 11;
	localparam int BYTE_W = 16;
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 32;
	localparam int ADDR_SHIFT = 10;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		ACT_INIT = 3'd0, ACT_ALLOC = 3'd1, ACT_COMMIT = 3'd2,
		ACT_ACQ_TX = 3'd3, ACT_ACQ_RX = 3'd4, ACT_RELEASE = 3'd5,
		ACT_NOP6 = 3'd6, ACT_NOP7 = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_BAD_ID = 3'd2,
		ST_BAD_LEN = 3'd3, ST_OVERRUN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE, BK_READ, BK_INIT, BK_OUT
	} back_state_t;

	localparam logic [0:0] CFG_BASE  = 1'b0;
	localparam logic [0:0] CFG_COUNT = 1'b1;

	// classified request handed from front to back
	typedef struct packed {
		action_t          action;
		logic [ID_W-1:0]  buffer_id;
		logic             len_bad;
		logic [LEN_W-1:0] length;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   granted_id;
		logic [ADDR_W-1:0] buffer_address;
		logic [LEN_W-1:0]  granted_length;
		logic [LVL_W-1:0]  ready_level;
		logic [LVL_W-1:0]  lowest_ready_level;
		logic [CNT_W-1:0]  underrun_total;
		logic [CNT_W-1:0]  overrun_total;
	} result_t;
endpackage
`default_nettype wire

/* rtl/bpq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_front: request intake and classification
// Unpacks a request, checks its length and queues it for the back end.
// ----------------------------------------------------------------------------
module bpq_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  [2:0]                 in_action,
	input  wire  [bpq_pkg::ID_W-1:0]   in_id,
	input  wire  [bpq_pkg::BYTE_W-1:0] in_bytes,
	output logic                       req_valid,
	input  wire                        req_ready,
	output bpq_pkg::req_t              req
);
	bpq_pkg::req_t fifo_q [bpq_pkg::QDEPTH];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	bpq_pkg::req_t new_req;
	logic          push, pop;

	always_comb begin
		new_req.action    = bpq_pkg::action_t'(in_action);
		new_req.buffer_id = in_id;
		new_req.len_bad   = in_bytes > bpq_pkg::BYTE_W'(bpq_pkg::BUFFER_BYTES);
		new_req.length    = in_bytes[bpq_pkg::LEN_W-1:0];
	end

	assign in_ready  = cnt_q != 2'(bpq_pkg::QDEPTH);
	assign push      = in_valid && in_ready;
	assign req_valid = cnt_q != 2'd0;
	assign pop       = req_valid && req_ready;
	assign req       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= new_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* rtl/bpq_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_back: queue and table engine
// Reads the rings and length table, updates pointers and counters, holds result.
// ----------------------------------------------------------------------------
module bpq_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         req_valid,
	output logic                        req_ready,
	input  bpq_pkg::req_t               req,
	input  wire  [bpq_pkg::ADDR_W-1:0]  cfg_base,
	input  wire  [bpq_pkg::LVL_W-1:0]   cfg_count,
	output logic                        res_valid,
	input  wire                         res_ready,
	output bpq_pkg::result_t            res
);
	localparam int IW = bpq_pkg::ID_W;
	localparam int LW = bpq_pkg::LVL_W;
	localparam logic [bpq_pkg::ADDR_SHIFT-1:0] ADDR_SHIFT_ZERO = '0;

	logic [IW-1:0]                 free_ring [bpq_pkg::MAX_BUFFERS];
	logic [IW-1:0]                 ready_ring [bpq_pkg::MAX_BUFFERS];
	logic [bpq_pkg::LEN_W-1:0]     len_mem [bpq_pkg::MAX_BUFFERS];
	logic [bpq_pkg::MAX_BUFFERS-1:0] len_vld_q;

	bpq_pkg::back_state_t state_q, state_d;
	bpq_pkg::req_t        cur_q;
	logic [IW-1:0]   free_head_q, free_tail_q, ready_head_q, ready_tail_q;
	logic [LW-1:0]   free_lvl_q, ready_cnt_q, min_q, cap_q, init_i_q;
	logic [bpq_pkg::ADDR_W-1:0] base_q;
	logic [bpq_pkg::CNT_W-1:0]  under_q, over_q;
	logic [IW-1:0]   free_rd_q, ready_rd_q;
	logic [bpq_pkg::LEN_W-1:0] len_rd_q;
	logic            len_pend_q;
	logic [LW-1:0]   n_cap;
	bpq_pkg::result_t res_q;

	function automatic logic [IW-1:0] adv(input logic [IW-1:0] i, input logic [LW-1:0] cap);
		logic [LW-1:0] n;
		n = {1'b0, i} + 1'b1;
		return (n >= cap) ? '0 : n[IW-1:0];
	endfunction

	always_comb begin
		n_cap = cfg_count;
		if (n_cap == '0) n_cap = LW'(1);
		if (n_cap > LW'(bpq_pkg::MAX_BUFFERS)) n_cap = LW'(bpq_pkg::MAX_BUFFERS);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpq_pkg::BK_IDLE: if (req_valid)
				state_d = (req.action == bpq_pkg::ACT_INIT) ? bpq_pkg::BK_INIT
				                                             : bpq_pkg::BK_READ;
			bpq_pkg::BK_READ: state_d = bpq_pkg::BK_OUT;
			bpq_pkg::BK_INIT: if (init_i_q == LW'(bpq_pkg::MAX_BUFFERS - 1))
				state_d = bpq_pkg::BK_OUT;
			bpq_pkg::BK_OUT:  if (res_ready) state_d = bpq_pkg::BK_IDLE;
			default:          state_d = bpq_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		req_ready = state_q == bpq_pkg::BK_IDLE;
		res_valid = state_q == bpq_pkg::BK_OUT;
		res       = res_q;
	end

	// ring head reads registered in BK_IDLE, at the edge that accepts a request
	always_ff @(posedge clk) begin
		if (state_q == bpq_pkg::BK_IDLE) begin
			free_rd_q  <= free_ring[free_head_q];
			ready_rd_q <= ready_ring[ready_head_q];
		end
		if (state_q == bpq_pkg::BK_INIT)
			free_ring[init_i_q[IW-1:0]] <= (init_i_q < cap_q) ? init_i_q[IW-1:0] : '0;
		if (state_q == bpq_pkg::BK_READ && cur_q.action == bpq_pkg::ACT_RELEASE
		    && cur_q.buffer_id < cap_q && free_lvl_q < cap_q)
			free_ring[free_tail_q] <= cur_q.buffer_id;
		if (state_q == bpq_pkg::BK_READ && cur_q.action == bpq_pkg::ACT_COMMIT
		    && cur_q.buffer_id < cap_q && !cur_q.len_bad)
			ready_ring[ready_tail_q] <= cur_q.buffer_id;
	end

	// release ignores the byte count, so only commit looks at the length check
	always_ff @(posedge clk) begin
		if (state_q == bpq_pkg::BK_READ) len_rd_q <= len_mem[ready_rd_q];
		if (state_q == bpq_pkg::BK_READ && cur_q.buffer_id < cap_q
		    && ((cur_q.action == bpq_pkg::ACT_COMMIT && !cur_q.len_bad)
		        || cur_q.action == bpq_pkg::ACT_RELEASE))
			len_mem[cur_q.buffer_id] <= (cur_q.action == bpq_pkg::ACT_COMMIT)
			                            ? cur_q.length : '0;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) cur_q <= req;
	end

	// result assembled in BK_READ; granted length patched in BK_OUT entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpq_pkg::BK_IDLE;
			free_head_q <= '0; free_tail_q <= '0; ready_head_q <= '0; ready_tail_q <= '0;
			free_lvl_q <= '0; ready_cnt_q <= '0; min_q <= '0; cap_q <= '0;
			init_i_q <= '0; base_q <= '0; under_q <= '0; over_q <= '0;
			len_vld_q <= '0; res_q <= '0; len_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bpq_pkg::BK_IDLE && req_valid && req.action == bpq_pkg::ACT_INIT) begin
				cap_q <= n_cap; base_q <= cfg_base; init_i_q <= '0;
			end
			if (state_q == bpq_pkg::BK_INIT) begin
				init_i_q <= init_i_q + 1'b1;
				if (init_i_q == LW'(bpq_pkg::MAX_BUFFERS - 1)) begin
					len_vld_q <= '0;
					free_head_q <= '0; free_tail_q <= '0; free_lvl_q <= cap_q;
					ready_head_q <= '0; ready_tail_q <= '0; ready_cnt_q <= '0;
					min_q <= cap_q; under_q <= '0; over_q <= '0;
					res_q.status <= bpq_pkg::ST_OK; res_q.granted_id <= '0;
					res_q.buffer_address <= base_q; res_q.granted_length <= '0;
					res_q.ready_level <= '0; res_q.lowest_ready_level <= cap_q;
					res_q.underrun_total <= '0; res_q.overrun_total <= '0;
				end
			end
			if (state_q == bpq_pkg::BK_READ) begin
				logic [IW-1:0] g;
				logic [LW-1:0] rc, mn;
				logic [bpq_pkg::CNT_W-1:0] un, ov;
				bpq_pkg::status_t st;
				logic grab_len;
				g = '0; rc = ready_cnt_q; mn = min_q; un = under_q; ov = over_q;
				st = bpq_pkg::ST_OK; grab_len = 1'b0;
				case (cur_q.action)
					bpq_pkg::ACT_ALLOC: begin
						if (free_lvl_q == '0) st = bpq_pkg::ST_EMPTY;
						else begin
							g = free_rd_q; free_head_q <= adv(free_head_q, cap_q);
							free_lvl_q <= free_lvl_q - 1'b1;
						end
					end
					bpq_pkg::ACT_COMMIT: begin
						g = cur_q.buffer_id;
						if (cur_q.buffer_id >= cap_q) st = bpq_pkg::ST_BAD_ID;
						else if (cur_q.len_bad) st = bpq_pkg::ST_BAD_LEN;
						else begin
							len_vld_q[cur_q.buffer_id] <= 1'b1;
							if (ready_cnt_q >= cap_q) begin
								ready_head_q <= adv(ready_head_q, cap_q);
								if (~&ov) ov = ov + 1'b1;
								st = bpq_pkg::ST_OVERRUN;
							end else rc = rc + 1'b1;
							ready_tail_q <= adv(ready_tail_q, cap_q);
						end
					end
					bpq_pkg::ACT_ACQ_TX, bpq_pkg::ACT_ACQ_RX: begin
						if (ready_cnt_q == '0) begin
							st = bpq_pkg::ST_EMPTY;
							if (cur_q.action == bpq_pkg::ACT_ACQ_TX && cap_q != '0 && ~&un)
								un = un + 1'b1;
						end else begin
							g = ready_rd_q; grab_len = len_vld_q[ready_rd_q];
							ready_head_q <= adv(ready_head_q, cap_q);
							rc = rc - 1'b1;
							if (cur_q.action == bpq_pkg::ACT_ACQ_TX && rc < mn) mn = rc;
						end
					end
					bpq_pkg::ACT_RELEASE: begin
						g = cur_q.buffer_id;
						if (cur_q.buffer_id >= cap_q) st = bpq_pkg::ST_BAD_ID;
						else begin
							len_vld_q[cur_q.buffer_id] <= 1'b1;
							if (free_lvl_q >= cap_q) begin
								if (~&ov) ov = ov + 1'b1;
								st = bpq_pkg::ST_OVERRUN;
							end else begin
								free_tail_q <= adv(free_tail_q, cap_q);
								free_lvl_q <= free_lvl_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
				ready_cnt_q <= rc; min_q <= mn; under_q <= un; over_q <= ov;
				len_pend_q <= grab_len;
				res_q.status <= st; res_q.granted_id <= g;
				res_q.buffer_address <= base_q + {g, ADDR_SHIFT_ZERO};
				res_q.granted_length <= '0;
				res_q.ready_level <= rc; res_q.lowest_ready_level <= mn;
				res_q.underrun_total <= un; res_q.overrun_total <= ov;
			end
			if (state_q == bpq_pkg::BK_OUT && len_pend_q) begin
				res_q.granted_length <= len_rd_q;
				len_pend_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/buffer_pool_free_ready_queues.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_pool_free_ready_queues: audio buffer pool with free and ready FIFOs
// Top level: config registers, request front end and queue engine.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tdata: action, buffer_id, byte_count) and each one
// gives exactly one result on m_axis. Configuration writes on cfg_* set the
// pool base (index 0) and buffer count (index 1); both are latched by init.
// The front queue registers each request before the back end takes it in
// BK_IDLE; the back end reads and executes it in BK_READ, then patches the
// granted length on entering BK_OUT before m_axis_tvalid rises, and takes no
// new request until m_axis accepts the result.
// Init walks all 128 ring entries, one per cycle.
// A two-entry queue in front keeps s_axis_tready high while a result waits;
// when m_axis stalls the queue fills and tready drops.
// After reset the pool is empty with capacity zero: alloc and acquire answer
// queue empty, commit and release bad id, until an init request arrives.
// A result is complete when m_axis_tvalid rises and is held stable until taken.
// ----------------------------------------------------------------------------
module buffer_pool_free_ready_queues (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [31:0]  s_axis_tdata,  // action[2:0], buffer_id[9:3], byte_count[25:10]
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// status[2:0], granted_id[9:3], buffer_address[41:10], granted_length[52:42],
	// ready_level[60:53], lowest_ready_level[68:61], underrun_total[100:69],
	// overrun_total[132:101]
	output logic [135:0] m_axis_tdata,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [0:0]   cfg_index,
	input  wire  [31:0]  cfg_data
);
	logic [31:0] base_q;
	logic [7:0]  count_q;
	logic        req_valid, req_ready, res_valid, res_hold_q;
	bpq_pkg::req_t    req;
	bpq_pkg::result_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= 8'd8;
		end else if (cfg_valid) begin
			if (cfg_index == bpq_pkg::CFG_BASE) base_q <= cfg_data;
			else count_q <= cfg_data[7:0];
		end
	end

	bpq_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_action(s_axis_tdata[2:0]), .in_id(s_axis_tdata[9:3]),
		.in_bytes(s_axis_tdata[25:10]),
		.req_valid, .req_ready, .req
	);

	// hold valid back through res_hold_q so the length patch lands first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_hold_q <= 1'b0;
		else res_hold_q <= res_valid && !(m_axis_tvalid && m_axis_tready);
	end
	assign m_axis_tvalid = res_valid && res_hold_q;

	bpq_back u_back (
		.clk, .arst_n, .req_valid, .req_ready, .req,
		.cfg_base(base_q), .cfg_count(count_q),
		.res_valid, .res_ready(m_axis_tready && m_axis_tvalid), .res
	);

	assign m_axis_tdata = {3'b000, res.overrun_total, res.underrun_total,
		res.lowest_ready_level, res.ready_level, res.granted_length,
		res.buffer_address, res.granted_id, res.status};
endmodule
`default_nettype wire

/* rtl/bpq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_checker: port-level checks of the buffer pool
// Watches the result stream: stall stability, status codes and level ranges.
// ----------------------------------------------------------------------------
module bpq_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [135:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
		else $error("bad status code");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[68:61] <= 8'd128 && m_axis_tdata[60:53] <= 8'd128)
		else $error("level out of range");
endmodule

bind buffer_pool_free_ready_queues bpq_checker u_bpq_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: buffer pool free/ready queues
// Drives pool requests and config writes with random idling on both sides and
// checks every result against a queue-level predictor of the pool.
// ----------------------------------------------------------------------------

class pool_scoreboard;
	bit [31:0] reg_base;
	bit [7:0]  reg_count;
	bit [31:0] base_lat;
	int        capacity;
	bit [6:0]  free_ring [bpq_pkg::MAX_BUFFERS];
	bit [6:0]  ready_ring [bpq_pkg::MAX_BUFFERS];
	bit [10:0] len_table [bpq_pkg::MAX_BUFFERS];
	int        free_head, free_tail, free_level;
	int        ready_head, ready_tail, ready_level;
	bit [7:0]  low_mark;
	bit [31:0] underruns, overruns;
	bit [132:0] pending [$];
	int        errors;
	int        requests, results;

	function new();
		reg_base = 0;
		reg_count = 8;
		base_lat = 0;
		capacity = 0;
		free_head = 0; free_tail = 0; free_level = 0;
		ready_head = 0; ready_tail = 0; ready_level = 0;
		low_mark = 0; underruns = 0; overruns = 0;
		errors = 0; requests = 0; results = 0;
		foreach (len_table[i]) begin
			len_table[i] = 0;
			free_ring[i] = 0;
			ready_ring[i] = 0;
		end
	endfunction

	function void write_reg(bit idx, bit [31:0] data);
		if (idx == bpq_pkg::CFG_BASE)
			reg_base = data;
		else
			reg_count = data[7:0];
	endfunction

	function int step_ptr(int p);
		return (p + 1 >= capacity) ? 0 : p + 1;
	endfunction

	function bit [31:0] sat_inc(bit [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	function void note_request(bpq_pkg::action_t act, bit [6:0] id, bit [15:0] bytes);
		bpq_pkg::status_t st;
		bit [6:0]  gid;
		bit [10:0] glen;
		bit [31:0] addr;
		int        n;
		st = bpq_pkg::ST_OK;
		gid = 0;
		glen = 0;
		requests++;
		case (act)
			bpq_pkg::ACT_INIT: begin
				n = reg_count;
				if (n < 1) n = 1;
				if (n > bpq_pkg::MAX_BUFFERS) n = bpq_pkg::MAX_BUFFERS;
				capacity = n;
				base_lat = reg_base;
				for (int i = 0; i < bpq_pkg::MAX_BUFFERS; i++) begin
					len_table[i] = 0;
					free_ring[i] = (i < n) ? i[6:0] : 7'd0;
				end
				free_head = 0; free_tail = 0; free_level = n;
				ready_head = 0; ready_tail = 0; ready_level = 0;
				low_mark = n[7:0];
				underruns = 0; overruns = 0;
			end
			bpq_pkg::ACT_ALLOC: begin
				if (free_level == 0) begin
					st = bpq_pkg::ST_EMPTY;
				end else begin
					gid = free_ring[free_head];
					free_head = step_ptr(free_head);
					free_level--;
				end
			end
			bpq_pkg::ACT_COMMIT: begin
				gid = id;
				if (id >= capacity) begin
					st = bpq_pkg::ST_BAD_ID;
				end else if (bytes > bpq_pkg::BUFFER_BYTES) begin
					st = bpq_pkg::ST_BAD_LEN;
				end else begin
					len_table[id] = bytes[10:0];
					// drop the oldest entry when the ready queue is full
					if (ready_level >= capacity) begin
						ready_head = step_ptr(ready_head);
						ready_level--;
						overruns = sat_inc(overruns);
						st = bpq_pkg::ST_OVERRUN;
					end
					ready_ring[ready_tail] = id;
					ready_tail = step_ptr(ready_tail);
					ready_level++;
				end
			end
			bpq_pkg::ACT_ACQ_TX, bpq_pkg::ACT_ACQ_RX: begin
				if (ready_level == 0) begin
					st = bpq_pkg::ST_EMPTY;
					if (act == bpq_pkg::ACT_ACQ_TX && capacity != 0)
						underruns = sat_inc(underruns);
				end else begin
					gid = ready_ring[ready_head];
					ready_head = step_ptr(ready_head);
					ready_level--;
					glen = len_table[gid];
					if (act == bpq_pkg::ACT_ACQ_TX && ready_level < low_mark)
						low_mark = ready_level[7:0];
				end
			end
			bpq_pkg::ACT_RELEASE: begin
				gid = id;
				if (id >= capacity) begin
					st = bpq_pkg::ST_BAD_ID;
				end else begin
					len_table[id] = 0;
					if (free_level >= capacity) begin
						overruns = sat_inc(overruns);
						st = bpq_pkg::ST_OVERRUN;
					end else begin
						free_ring[free_tail] = id;
						free_tail = step_ptr(free_tail);
						free_level++;
					end
				end
			end
			default: ;
		endcase
		addr = base_lat + {gid, 10'b0};
		pending.push_back({overruns, underruns, low_mark, ready_level[7:0], glen, addr,
			gid, st});
	endfunction

	function void check_result(bit [135:0] data);
		bit [132:0] exp_r;
		results++;
		if (pending.size() == 0) begin
			$display("%0t: result with no request pending: %h", $time, data);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (data[2:0] != exp_r[2:0]) begin
			$display("%0t: status exp %0d got %0d", $time, exp_r[2:0], data[2:0]);
			errors++;
		end
		if (data[9:3] != exp_r[9:3]) begin
			$display("%0t: granted_id exp %0d got %0d", $time, exp_r[9:3], data[9:3]);
			errors++;
		end
		if (data[41:10] != exp_r[41:10]) begin
			$display("%0t: buffer_address exp %h got %h", $time, exp_r[41:10], data[41:10]);
			errors++;
		end
		if (data[52:42] != exp_r[52:42]) begin
			$display("%0t: granted_length exp %0d got %0d", $time, exp_r[52:42],
				data[52:42]);
			errors++;
		end
		if (data[60:53] != exp_r[60:53]) begin
			$display("%0t: ready_level exp %0d got %0d", $time, exp_r[60:53], data[60:53]);
			errors++;
		end
		if (data[68:61] != exp_r[68:61]) begin
			$display("%0t: lowest_ready_level exp %0d got %0d", $time, exp_r[68:61],
				data[68:61]);
			errors++;
		end
		if (data[100:69] != exp_r[100:69]) begin
			$display("%0t: underrun_total exp %0d got %0d", $time, exp_r[100:69],
				data[100:69]);
			errors++;
		end
		if (data[132:101] != exp_r[132:101]) begin
			$display("%0t: overrun_total exp %0d got %0d", $time, exp_r[132:101],
				data[132:101]);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int STALL_LIMIT = 20000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [135:0] m_axis_tdata;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [0:0]   cfg_index = 0;
	logic [31:0]  cfg_data = 0;

	pool_scoreboard pool = new();
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;
	int cfg_writes = 0;

	buffer_pool_free_ready_queues dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// sample both handshakes at the edge and keep the stall watchdog
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			pool.note_request(bpq_pkg::action_t'(s_axis_tdata[2:0]), s_axis_tdata[9:3],
				s_axis_tdata[25:10]);
		if (m_axis_tvalid && m_axis_tready)
			pool.check_result(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(bpq_pkg::action_t act, bit [6:0] id, bit [15:0] bytes);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'd0, bytes, id, act};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 0;
		while (pool.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(bit idx, bit [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		pool.write_reg(idx, data);
		cfg_valid <= 0;
		cfg_writes++;
	endtask

	task automatic random_request();
		int               pick;
		bpq_pkg::action_t act;
		bit [6:0]         id;
		bit [15:0]        bytes;
		pick = $urandom_range(99);
		if (pick < 3) act = bpq_pkg::ACT_INIT;
		else if (pick < 21) act = bpq_pkg::ACT_ALLOC;
		else if (pick < 46) act = bpq_pkg::ACT_COMMIT;
		else if (pick < 66) act = bpq_pkg::ACT_ACQ_TX;
		else if (pick < 76) act = bpq_pkg::ACT_ACQ_RX;
		else if (pick < 96) act = bpq_pkg::ACT_RELEASE;
		else act = $urandom_range(1) ? bpq_pkg::ACT_NOP6 : bpq_pkg::ACT_NOP7;
		if (pool.capacity > 0 && $urandom_range(99) < 85)
			id = 7'($urandom_range(pool.capacity - 1));
		else
			id = 7'($urandom);
		pick = $urandom_range(99);
		if (pick < 80) bytes = 16'($urandom_range(bpq_pkg::BUFFER_BYTES));
		else if (pick < 88) bytes = 16'(bpq_pkg::BUFFER_BYTES);
		else bytes = 16'($urandom);
		send_request(act, id, bytes);
	endtask

	initial begin
		bit [7:0]  counts [6];
		bit [31:0] bases [6];
		counts = '{8'd3, 8'd128, 8'd0, 8'd255, 8'd1, 8'd0};
		bases = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FC00, 32'h0};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// before any init the pool has no capacity
		send_request(bpq_pkg::ACT_ALLOC, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_COMMIT, 7'd0, 16'd16);
		send_request(bpq_pkg::ACT_ACQ_TX, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ACQ_RX, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_RELEASE, 7'd0, 16'd0);
		wait_idle();
		cfg_write(bpq_pkg::CFG_BASE, 32'hFFFF_F000);
		cfg_write(bpq_pkg::CFG_COUNT, 32'd2);
		send_request(bpq_pkg::ACT_INIT, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ALLOC, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ALLOC, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ALLOC, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_COMMIT, 7'd0, 16'(bpq_pkg::BUFFER_BYTES));
		send_request(bpq_pkg::ACT_COMMIT, 7'd1, 16'd0);
		send_request(bpq_pkg::ACT_COMMIT, 7'd0, 16'd7);
		send_request(bpq_pkg::ACT_COMMIT, 7'd2, 16'd5);
		send_request(bpq_pkg::ACT_COMMIT, 7'd1, 16'(bpq_pkg::BUFFER_BYTES + 1));
		send_request(bpq_pkg::ACT_COMMIT, 7'd127, 16'hFFFF);
		send_request(bpq_pkg::ACT_ACQ_TX, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ACQ_TX, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ACQ_TX, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_ACQ_RX, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_RELEASE, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_RELEASE, 7'd1, 16'd0);
		send_request(bpq_pkg::ACT_RELEASE, 7'd0, 16'hFFFF);
		send_request(bpq_pkg::ACT_RELEASE, 7'd127, 16'd0);
		send_request(bpq_pkg::ACT_NOP6, 7'h7F, 16'hFFFF);
		send_request(bpq_pkg::ACT_NOP7, 7'd0, 16'd0);
		send_request(bpq_pkg::ACT_INIT, 7'd0, 16'd0);

		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			case (phase / 2)
				0: begin send_idle = 22; recv_idle = 71; end
				1: begin send_idle = 71; recv_idle = 22; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			if (counts[phase] == 0 && phase == 5) counts[phase] = 8'($urandom_range(1, 128));
			if (bases[phase] == 0 && phase != 0) bases[phase] = $urandom;
			cfg_write(bpq_pkg::CFG_BASE, bases[phase]);
			cfg_write(bpq_pkg::CFG_COUNT, {24'd0, counts[phase]});
			send_request(bpq_pkg::ACT_INIT, 7'd0, 16'd0);
			repeat (108) random_request();
		end

		wait_idle();
		$display("Covered %0d requests and %0d results over %0d config writes,",
			pool.requests, pool.results, cfg_writes);
		$display("pool sizes 1 to 128 with three idling mixes on both streams.");
		if (pool.errors == 0 && pool.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
